FILE: src/xbr_pkg.sv
// Package for the XMODEM block receiver: codes, sizes, word and command types.
// Used by xbr_ctrl, xbr_datapath and xmodem_block_receiver_core; depends on nothing.
package xbr_pkg;

    localparam int DATA_BYTES = 5;
    localparam int POS_W      = $clog2(DATA_BYTES + 3);
    localparam int IDX_W      = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_ERROR = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_NAK   = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } xbr_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       seq_mismatch;
        logic       last;
    } xbr_out_t;

    // Controller to datapath
    typedef struct packed {
        logic       idx_clr;
        logic       idx_inc;
        logic       cap_num;
        logic       cap_inv;
        logic       cap_data;
        logic       rd_issue;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
        logic       ack_check;
        logic       exp_reset;
        logic       exp_bump;
    } xbr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic blk_ok;
        logic rd_etx;
        logic idx_last;
        logic out_free;
    } xbr_stat_t;

endpackage

FILE: src/xbr_datapath.sv
// Datapath of the XMODEM block receiver: header registers, payload store,
// running checksum, expected block number and the output word register. Uses xbr_pkg.
module xbr_datapath import xbr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  xbr_in_t   in_word,
    input  xbr_cmd_t  cmd,
    output xbr_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output xbr_out_t  m_data
);

    logic [7:0]       store_mem [DATA_BYTES];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       block_num_reg;
    logic [7:0]       block_inv_reg;
    logic [7:0]       expected_reg;
    logic             m_valid_reg;
    xbr_out_t         m_data_reg;
    xbr_out_t         out_next;

    always_ff @(posedge aclk) begin
        if (cmd.cap_data) begin
            store_mem[idx_reg] <= in_word.rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            block_num_reg <= '0;
            block_inv_reg <= '0;
            expected_reg  <= 8'd1;
        end else begin
            if (cmd.idx_clr) begin
                idx_reg <= '0;
                sum_reg <= '0;
            end else if (cmd.cap_data) begin
                idx_reg <= idx_reg + 1'b1;
                sum_reg <= sum_reg + in_word.rx_byte;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.cap_num) begin
                block_num_reg <= in_word.rx_byte;
            end
            if (cmd.cap_inv) begin
                block_inv_reg <= in_word.rx_byte;
            end
            if (cmd.exp_reset) begin
                expected_reg <= 8'd1;
            end else if (cmd.exp_bump) begin
                expected_reg <= expected_reg + 8'd1;
            end
        end
    end

    always_comb begin
        out_next              = '0;
        out_next.kind         = cmd.out_kind;
        out_next.last         = cmd.out_last;
        out_next.data_byte    = (cmd.out_kind == KIND_DATA) ? rd_data_reg : 8'd0;
        out_next.seq_mismatch = cmd.ack_check && (block_num_reg != expected_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign stat.blk_ok   = (~block_num_reg == block_inv_reg) && (sum_reg == in_word.rx_byte);
    assign stat.rd_etx   = (rd_data_reg == CH_ETX);
    assign stat.idx_last = (idx_reg == IDX_W'(DATA_BYTES - 1));
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/xbr_ctrl.sv
// Controller of the XMODEM block receiver: session phase, byte position and
// the sequencer that plays a good block out of the store. Uses xbr_pkg.
module xbr_ctrl import xbr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  xbr_in_t   in_word,
    input  xbr_stat_t stat,
    output xbr_cmd_t  cmd
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HUNT  = 2'd1;
    localparam logic [1:0] PH_BLOCK = 2'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_ACK  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_word.req_type)
                        REQ_START: begin
                            phase_next    = PH_HUNT;
                            pos_next      = '0;
                            cmd.exp_reset = 1'b1;
                            cmd.out_load  = 1'b1;
                            cmd.out_kind  = KIND_NAK;
                            cmd.out_last  = 1'b1;
                        end
                        REQ_ERROR: begin
                            if (phase_reg == PH_BLOCK) begin
                                phase_next   = PH_HUNT;
                                pos_next     = '0;
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_NAK;
                                cmd.out_last = 1'b1;
                            end else if (phase_reg == PH_HUNT) begin
                                phase_next   = PH_IDLE;
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_ABORT;
                                cmd.out_last = 1'b1;
                            end
                        end
                        REQ_BYTE: begin
                            if (phase_reg == PH_HUNT) begin
                                if (in_word.rx_byte == CH_EOT) begin
                                    phase_next   = PH_IDLE;
                                    cmd.out_load = 1'b1;
                                    cmd.out_kind = KIND_ACK;
                                    cmd.out_last = 1'b1;
                                end else if (in_word.rx_byte == CH_SOH) begin
                                    phase_next  = PH_BLOCK;
                                    pos_next    = '0;
                                    cmd.idx_clr = 1'b1;
                                end
                            end else if (phase_reg == PH_BLOCK) begin
                                if (pos_reg == POS_W'(0)) begin
                                    cmd.cap_num = 1'b1;
                                    pos_next    = pos_reg + 1'b1;
                                end else if (pos_reg == POS_W'(1)) begin
                                    cmd.cap_inv = 1'b1;
                                    pos_next    = pos_reg + 1'b1;
                                end else if (pos_reg < POS_W'(DATA_BYTES + 2)) begin
                                    cmd.cap_data = 1'b1;
                                    pos_next     = pos_reg + 1'b1;
                                end else begin
                                    phase_next = PH_HUNT;
                                    pos_next   = '0;
                                    if (stat.blk_ok) begin
                                        cmd.idx_clr = 1'b1;
                                        state_next  = ST_READ;
                                    end else begin
                                        cmd.out_load = 1'b1;
                                        cmd.out_kind = KIND_NAK;
                                        cmd.out_last = 1'b1;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the word fits; drop ETX pad bytes
                if (stat.rd_etx || stat.out_free) begin
                    if (!stat.rd_etx) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_DATA;
                    end
                    if (stat.idx_last) begin
                        state_next = ST_ACK;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_ACK: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = KIND_ACK;
                    cmd.out_last  = 1'b1;
                    cmd.ack_check = 1'b1;
                    cmd.exp_bump  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: src/xmodem_block_receiver_core.sv
// Top level of the XMODEM checksum block receiver.
// Depends on xbr_pkg, xbr_ctrl and xbr_datapath.
//
//   channel  direction  handshake           word
//   s_       in         s_valid / s_ready   xbr_in_t  (req_type, rx_byte)
//   m_       out        m_valid / m_ready   xbr_out_t (kind, data_byte, seq_mismatch, last)
//
// Flow: a byte, start or error event is taken on s_, and its single word (if any)
// shows on m_ in the cycle after. After the checksum byte of a good block, the
// payload store, which has one registered read port, is played out byte by byte: a read
// state, then a check/emit state for each stored byte, then an ACK state.
// Reset: aresetn low at a clock edge clears the sequencer, phase and output valid,
// and sets the expected block number to one.
// Stalls: the output register holds a word until m_ready; s_ready drops while a
// block plays out or while the output register is full and not being drained.
module xmodem_block_receiver_core import xbr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  xbr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output xbr_out_t m_data
);

    xbr_cmd_t  cmd;
    xbr_stat_t stat;

    // Sequencing: session phase, header/payload position, block playout
    xbr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_word (s_data),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and checks: header, payload store, checksum, output word register
    xbr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_word (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for xmodem_block_receiver_core: drives received bytes and session events,
// predicts every response word and checks the m_ channel against it.
// Depends on xbr_pkg and the receiver RTL only.
module tb_top;
    import xbr_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         BLOCK_LEN       = DATA_BYTES + 3;  // number, complement, data, sum
    localparam int         RANDOM_WORDS    = 80;

    typedef enum logic [1:0] {LINK_IDLE, LINK_HUNT, LINK_BLOCK} link_phase_t;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_EVERY_THIRD} ready_mode_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    xbr_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    xbr_out_t m_data;

    // Receiver shadow state
    link_phase_t link_phase;
    int          blk_pos;
    logic [7:0]  blk_num;
    logic [7:0]  blk_inv;
    logic [7:0]  rx_store [DATA_BYTES];
    logic [7:0]  next_block;

    xbr_out_t expected_words [$];
    int       fail_count;
    int       words_sent;

    // Sender and receiver pacing
    logic        sender_gaps_on;
    int          burst_left;
    logic        hold_off_req;
    ready_mode_t ready_mode;
    int          mode_left;
    int          rdy_tick;

    xmodem_block_receiver_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic xbr_out_t make_word(input logic [1:0] kind, input logic [7:0] data,
                                           input logic mis);
        xbr_out_t w;
        w.kind         = kind;
        w.data_byte    = data;
        w.seq_mismatch = mis;
        w.last         = 1'b0;
        return w;
    endfunction

    function automatic logic [7:0] payload_sum(input logic [DATA_BYTES*8-1:0] payload);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < DATA_BYTES; i++) sum += payload[i*8 +: 8];
        return sum;
    endfunction

    // Bias payload toward pad bytes and the byte extremes.
    function automatic logic [DATA_BYTES*8-1:0] random_payload();
        logic [DATA_BYTES*8-1:0] p;
        for (int i = 0; i < DATA_BYTES; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    p[i*8 +: 8] = CH_ETX;
                2:       p[i*8 +: 8] = 8'h00;
                3:       p[i*8 +: 8] = 8'hFF;
                default: p[i*8 +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    // Work out the response words of one accepted input word and queue them.
    task automatic predict_response(input xbr_in_t w);
        xbr_out_t   words [$];
        logic [7:0] sum;
        case (w.req_type)
            REQ_START: begin
                link_phase = LINK_HUNT;
                blk_pos    = 0;
                next_block = 8'd1;
                words      = {words, make_word(KIND_NAK, 8'h00, 1'b0)};
            end
            REQ_ERROR: begin
                if (link_phase == LINK_BLOCK) begin
                    link_phase = LINK_HUNT;
                    blk_pos    = 0;
                    words      = {words, make_word(KIND_NAK, 8'h00, 1'b0)};
                end else if (link_phase == LINK_HUNT) begin
                    link_phase = LINK_IDLE;
                    words      = {words, make_word(KIND_ABORT, 8'h00, 1'b0)};
                end
            end
            REQ_BYTE: begin
                if (link_phase == LINK_HUNT) begin
                    if (w.rx_byte == CH_EOT) begin
                        link_phase = LINK_IDLE;
                        words      = {words, make_word(KIND_ACK, 8'h00, 1'b0)};
                    end else if (w.rx_byte == CH_SOH) begin
                        link_phase = LINK_BLOCK;
                        blk_pos    = 0;
                    end
                end else if (link_phase == LINK_BLOCK) begin
                    if (blk_pos == 0) begin
                        blk_num = w.rx_byte;
                        blk_pos = 1;
                    end else if (blk_pos == 1) begin
                        blk_inv = w.rx_byte;
                        blk_pos = 2;
                    end else if (blk_pos < DATA_BYTES + 2) begin
                        rx_store[blk_pos - 2] = w.rx_byte;
                        blk_pos++;
                    end else begin
                        // checksum byte closes the block
                        link_phase = LINK_HUNT;
                        blk_pos    = 0;
                        sum        = 8'h00;
                        for (int i = 0; i < DATA_BYTES; i++) sum += rx_store[i];
                        if (8'(8'hFF - blk_num) != blk_inv || sum != w.rx_byte) begin
                            words = {words, make_word(KIND_NAK, 8'h00, 1'b0)};
                        end else begin
                            for (int i = 0; i < DATA_BYTES; i++)
                                if (rx_store[i] != CH_ETX)
                                    words = {words, make_word(KIND_DATA, rx_store[i], 1'b0)};
                            words = {words, make_word(KIND_ACK, 8'h00, blk_num != next_block)};
                            next_block = next_block + 8'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (words.size() > 0) words[words.size() - 1].last = 1'b1;
        expected_words = {expected_words, words};
    endtask

    // Predict on input acceptance, compare on output acceptance.
    always @(posedge aclk) begin
        xbr_out_t e;
        if (aresetn) begin
            if (s_valid && s_ready) predict_response(s_data);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word kind %0d data %h", $time, m_data.kind,
                             m_data.data_byte);
                    fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    if (m_data.kind !== e.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, e.kind,
                                 m_data.kind);
                        fail_count++;
                    end
                    if (m_data.data_byte !== e.data_byte) begin
                        $display("%0t: data_byte expected %h actual %h", $time, e.data_byte,
                                 m_data.data_byte);
                        fail_count++;
                    end
                    if (m_data.seq_mismatch !== e.seq_mismatch) begin
                        $display("%0t: seq_mismatch expected %b actual %b", $time,
                                 e.seq_mismatch, m_data.seq_mismatch);
                        fail_count++;
                    end
                    if (m_data.last !== e.last) begin
                        $display("%0t: last expected %b actual %b", $time, e.last, m_data.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Offer one word and hold it until accepted; then advance the burst/gap pattern.
    task automatic send_word(input logic [1:0] req, input logic [7:0] b);
        int gap;
        s_valid        = 1'b1;
        s_data.req_type = req;
        s_data.rx_byte  = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
        if (sender_gaps_on && burst_left == 0) begin
            gap            = $urandom_range(1, 6);
            s_valid        = 1'b0;
            s_data.rx_byte = 8'($urandom);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(0, 10);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Send SOH and then the first upto bytes of the block body.
    task automatic send_block(input logic [7:0] num, input logic [7:0] inv,
                              input logic [DATA_BYTES*8-1:0] payload,
                              input logic [7:0] csum, input int upto);
        logic [7:0] body [BLOCK_LEN];
        body[0] = num;
        body[1] = inv;
        for (int i = 0; i < DATA_BYTES; i++) body[i + 2] = payload[i*8 +: 8];
        body[BLOCK_LEN - 1] = csum;
        send_word(REQ_BYTE, CH_SOH);
        for (int i = 0; i < upto; i++) send_word(REQ_BYTE, body[i]);
    endtask

    // Receiver: switch ready patterns now and then; serve a long hold-off on request.
    initial begin
        m_ready    = 1'b0;
        mode_left  = 0;
        rdy_tick   = 0;
        ready_mode = RDY_ALWAYS;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready      = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            rdy_tick++;
            case (ready_mode)
                RDY_ALWAYS: m_ready = 1'b1;
                RDY_COIN:   m_ready = 1'($urandom_range(0, 1));
                RDY_SPARSE: m_ready = ($urandom_range(0, 3) == 0);
                default:    m_ready = (rdy_tick % 3 != 0);
            endcase
        end
    end

    // Nothing before a session start may answer.
    task automatic test_idle_requests();
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, CH_SOH);
        send_word(REQ_ERROR, 8'($urandom));
        send_word(REQ_UNKNOWN, 8'hA5);
    endtask

    // Full block with pad bytes and extremes, hunt noise, EOT close.
    task automatic test_good_block();
        logic [DATA_BYTES*8-1:0] p;
        p = {8'h7F, 8'h80, 8'hFF, CH_ETX, 8'h00};
        send_word(REQ_START, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_UNKNOWN, 8'h5A);
        send_block(8'd1, 8'd254, p, payload_sum(p), BLOCK_LEN);
        send_word(REQ_BYTE, CH_EOT);
    endtask

    // Abort while hunting, error inside a block, restart inside a block.
    task automatic test_error_paths();
        send_word(REQ_START, 8'h00);
        send_word(REQ_ERROR, 8'h00);
        send_word(REQ_START, 8'h00);
        send_block(8'd1, 8'd254, '0, 8'h00, 1);
        send_word(REQ_ERROR, 8'h00);
        send_block(8'd2, 8'd253, '0, 8'h00, 4);
        send_word(REQ_START, 8'h00);
        send_word(REQ_ERROR, 8'h00);
    endtask

    // Sessions of mostly well-formed blocks, with corrupted and broken ones mixed in.
    task automatic test_random_sessions();
        int                      first;
        int                      nblk;
        logic [7:0]              gen_block;
        logic [7:0]              num;
        logic [7:0]              inv;
        logic [7:0]              csum;
        logic [DATA_BYTES*8-1:0] p;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            gen_block      = 8'd1;
            send_word(REQ_START, 8'($urandom));
            nblk = $urandom_range(1, 6);
            for (int k = 0; k < nblk; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    num = 8'($urandom);
                    if (num == CH_SOH || num == CH_EOT) num = 8'h20;
                    send_word(REQ_BYTE, num);
                end
                if ($urandom_range(0, 19) == 0) send_word(REQ_UNKNOWN, 8'($urandom));
                p    = random_payload();
                num  = gen_block;
                inv  = 8'hFF - gen_block;
                csum = payload_sum(p);
                case ($urandom_range(0, 19))
                    0, 1: inv  = inv ^ 8'(1 << $urandom_range(0, 7));
                    2, 3: csum = csum + 8'($urandom_range(1, 255));
                    4, 5: begin
                        num = gen_block + 8'($urandom_range(1, 255));
                        inv = 8'hFF - num;
                    end
                    6: begin
                        send_block(num, inv, p, csum, $urandom_range(0, BLOCK_LEN - 1));
                        send_word(REQ_ERROR, 8'($urandom));
                        continue;
                    end
                    7: begin
                        send_block(num, inv, p, csum, $urandom_range(0, BLOCK_LEN - 1));
                        send_word(REQ_START, 8'($urandom));
                        gen_block = 8'd1;
                        continue;
                    end
                    8: begin
                        p    = {DATA_BYTES{CH_ETX}};
                        csum = payload_sum(p);
                    end
                    default: ;
                endcase
                send_block(num, inv, p, csum, BLOCK_LEN);
                if (inv == 8'(8'hFF - num) && csum == payload_sum(p)) gen_block++;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: send_word(REQ_ERROR, 8'($urandom));
                5, 6, 7:       ;  // next session start lands inside this one
                default:       send_word(REQ_BYTE, CH_EOT);
            endcase
        end
        sender_gaps_on = 1'b1;
    endtask

    // Hold the receiver off while full blocks go in back to back, so the input stalls.
    task automatic test_backpressure();
        logic [DATA_BYTES*8-1:0] p;
        sender_gaps_on = 1'b0;
        hold_off_req   = 1'b1;
        send_word(REQ_START, 8'h00);
        for (int k = 1; k <= 3; k++) begin
            p = {8'h10, 8'hFE, 8'h01, 8'h00, 8'(k)};
            send_block(8'(k), 8'(8'hFF - k), p, payload_sum(p), BLOCK_LEN);
        end
        send_word(REQ_BYTE, CH_EOT);
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        hold_off_req   = 1'b0;
        sender_gaps_on = 1'b1;
        burst_left     = 0;
        fail_count     = 0;
        words_sent     = 0;
        link_phase     = LINK_IDLE;
        blk_pos        = 0;
        blk_num        = 8'h00;
        blk_inv        = 8'h00;
        next_block     = 8'd1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_requests();
        test_good_block();
        test_error_paths();
        test_random_sessions();
        test_backpressure();

        s_valid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        // catch stray words after the last expected one
        repeat (4 * DATA_BYTES + 16) @(posedge aclk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
